// ===== design/spc_pkg.sv =====
package spc_pkg;

  // Field widths
  localparam int CMD_W     = 3;
  localparam int AMT_W     = 17;
  localparam int ANG_W     = 16;
  localparam int PUL_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // Datapath widths
  localparam int OP_W      = 17;  // multiplier operands and divisor
  localparam int PROD_W    = 2 * OP_W;
  localparam int TGT_W     = 22;  // widest target angle before clamping
  localparam int SUM_W     = PROD_W + 1;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int ADDR_W    = 5;

  // Percent scaling: floor(x / 10000) as (x * ceil(2^45 / 10000)) >> 45, exact for x < 2^32
  localparam int PCT_MAG_W   = 32;
  localparam int RECIP_SHIFT = 45;
  localparam int PCT_Q_W     = 2 * PCT_MAG_W - RECIP_SHIFT;

  localparam logic [OP_W-1:0]      PCT_SCALE      = OP_W'(10000);
  localparam logic [PCT_MAG_W-1:0] PCT_ROUND      = 32'd9999;
  localparam logic [PCT_MAG_W-1:0] RECIP_10K      = 32'hD1B7_1759;
  localparam logic [PUL_W-1:0]     PULSE_MAX_CODE = '1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_MOVE_TO     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE_BY_DEG = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE_BY_PCT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CENTER      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SLEEP       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WAKE        = 3'd5;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd3;

  localparam logic signed [ANG_W-1:0] MIN_ANGLE_RST = 16'sd0;
  localparam logic signed [ANG_W-1:0] MAX_ANGLE_RST = 16'sd18000;
  localparam logic [PUL_W-1:0]        MIN_PULSE_RST = 15'd500;
  localparam logic [PUL_W-1:0]        MAX_PULSE_RST = 15'd2500;

  // Micro-operations of the datapath
  typedef enum logic [4:0] {
    U_NOP,
    U_TGT_AMT,
    U_TGT_REL,
    U_TGT_CTR,
    U_MUL_PCT,
    U_PCT_MAG,
    U_PCT_RECIP,
    U_TGT_Q,
    U_CLAMP,
    U_MUL_PULSE,
    U_DIV_SPAN,
    U_PULSE_Q,
    U_PULSE_MIN,
    U_DRIVE,
    U_WAKE,
    U_SLEEP,
    U_NODRIVE,
    U_EMIT
  } uop_t;

  // Sequencing conditions
  typedef enum logic [2:0] {
    C_DISPATCH,
    C_NEXT,
    C_JUMP,
    C_WAIT_DIV,
    C_SPAN0,
    C_AWAKE,
    C_EMIT
  } cond_t;

  typedef struct packed {
    uop_t              uop;
    cond_t             cond;
    logic [ADDR_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic en;
    logic load;
    uop_t uop;
  } ctl_t;

  typedef struct packed {
    logic div_busy;
    logic span_zero;
    logic asleep;
    logic out_full;
  } stat_t;

  // Program addresses
  localparam logic [ADDR_W-1:0] A_IDLE       = 5'd0;
  localparam logic [ADDR_W-1:0] A_MOVE_TO    = 5'd1;
  localparam logic [ADDR_W-1:0] A_MOVE_BY    = 5'd2;
  localparam logic [ADDR_W-1:0] A_CENTER     = 5'd3;
  localparam logic [ADDR_W-1:0] A_PCT        = 5'd4;
  localparam logic [ADDR_W-1:0] A_PCT_MAG    = 5'd5;
  localparam logic [ADDR_W-1:0] A_PCT_RECIP  = 5'd6;
  localparam logic [ADDR_W-1:0] A_PCT_ADD    = 5'd7;
  localparam logic [ADDR_W-1:0] A_CLAMP      = 5'd8;
  localparam logic [ADDR_W-1:0] A_PULSE      = 5'd9;
  localparam logic [ADDR_W-1:0] A_PULSE_DIV  = 5'd10;
  localparam logic [ADDR_W-1:0] A_PULSE_WAIT = 5'd11;
  localparam logic [ADDR_W-1:0] A_PULSE_Q    = 5'd12;
  localparam logic [ADDR_W-1:0] A_PULSE_MIN  = 5'd13;
  localparam logic [ADDR_W-1:0] A_DRIVE      = 5'd14;
  localparam logic [ADDR_W-1:0] A_EMIT       = 5'd15;
  localparam logic [ADDR_W-1:0] A_WAKE       = 5'd16;
  localparam logic [ADDR_W-1:0] A_WAKE_CLR   = 5'd17;
  localparam logic [ADDR_W-1:0] A_SLEEP      = 5'd18;
  localparam logic [ADDR_W-1:0] A_NODRIVE    = 5'd19;
  localparam logic [ADDR_W-1:0] A_LAST       = A_NODRIVE;

  function automatic uword_t uw(input uop_t u, input cond_t c, input logic [ADDR_W-1:0] t);
    uword_t w;
    w.uop    = u;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // Control store
  function automatic uword_t ucode_rom(input logic [ADDR_W-1:0] a);
    uword_t w;
    unique case (a)
      A_IDLE:       w = uw(U_NOP,       C_DISPATCH, A_IDLE);
      A_MOVE_TO:    w = uw(U_TGT_AMT,   C_JUMP,     A_CLAMP);
      A_MOVE_BY:    w = uw(U_TGT_REL,   C_JUMP,     A_CLAMP);
      A_CENTER:     w = uw(U_TGT_CTR,   C_JUMP,     A_CLAMP);
      A_PCT:        w = uw(U_MUL_PCT,   C_NEXT,     A_IDLE);
      A_PCT_MAG:    w = uw(U_PCT_MAG,   C_NEXT,     A_IDLE);
      A_PCT_RECIP:  w = uw(U_PCT_RECIP, C_NEXT,     A_IDLE);
      A_PCT_ADD:    w = uw(U_TGT_Q,     C_NEXT,     A_IDLE);
      A_CLAMP:      w = uw(U_CLAMP,     C_NEXT,     A_IDLE);
      A_PULSE:      w = uw(U_MUL_PULSE, C_SPAN0,    A_PULSE_MIN);
      A_PULSE_DIV:  w = uw(U_DIV_SPAN,  C_NEXT,     A_IDLE);
      A_PULSE_WAIT: w = uw(U_NOP,       C_WAIT_DIV, A_IDLE);
      A_PULSE_Q:    w = uw(U_PULSE_Q,   C_JUMP,     A_DRIVE);
      A_PULSE_MIN:  w = uw(U_PULSE_MIN, C_NEXT,     A_IDLE);
      A_DRIVE:      w = uw(U_DRIVE,     C_NEXT,     A_IDLE);
      A_EMIT:       w = uw(U_EMIT,      C_EMIT,     A_IDLE);
      A_WAKE:       w = uw(U_NOP,       C_AWAKE,    A_NODRIVE);
      A_WAKE_CLR:   w = uw(U_WAKE,      C_JUMP,     A_PULSE);
      A_SLEEP:      w = uw(U_SLEEP,     C_JUMP,     A_EMIT);
      A_NODRIVE:    w = uw(U_NODRIVE,   C_JUMP,     A_EMIT);
      default:      w = uw(U_NOP,       C_JUMP,     A_IDLE);
    endcase
    return w;
  endfunction

  // Entry point of each command; unknown commands give a result that drives nothing
  function automatic logic [ADDR_W-1:0] entry_of(input logic [CMD_W-1:0] c);
    logic [ADDR_W-1:0] a;
    unique case (c)
      CMD_MOVE_TO:     a = A_MOVE_TO;
      CMD_MOVE_BY_DEG: a = A_MOVE_BY;
      CMD_MOVE_BY_PCT: a = A_PCT;
      CMD_CENTER:      a = A_CENTER;
      CMD_SLEEP:       a = A_SLEEP;
      CMD_WAKE:        a = A_WAKE;
      default:         a = A_NODRIVE;
    endcase
    return a;
  endfunction

endpackage

// ===== design/spc_if.sv =====
interface spc_cmd_if import spc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [AMT_W-1:0] amount;

  modport source (output valid, output command, output amount, input ready);
  modport sink   (input valid, input command, input amount, output ready);
endinterface

interface spc_res_if import spc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    write_strobe;
  logic [PUL_W-1:0]        pin_value;
  logic signed [ANG_W-1:0] angle_now;
  logic                    asleep;

  modport source (output valid, output write_strobe, output pin_value, output angle_now,
                  output asleep, input ready);
  modport sink   (input valid, input write_strobe, input pin_value, input angle_now,
                  input asleep, output ready);
endinterface

// ===== design/spc_divider.sv =====
module spc_divider import spc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [PROD_W-1:0] dividend,
  input  logic signed [OP_W-1:0]   divisor,
  output logic                     busy,
  output logic signed [PROD_W-1:0] quotient
);

  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] work;   // dividend bits shift out, quotient bits shift in
  logic [OP_W-1:0]   rem;
  logic [OP_W-1:0]   den;
  logic              neg;

  logic [OP_W:0]     trial;
  logic              take;

  assign trial = {rem, work[PROD_W-1]};
  assign take  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_STEPS);
      neg  <= dividend[PROD_W-1] ^ divisor[OP_W-1];
      work <= dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
      den  <= divisor[OP_W-1] ? OP_W'(-divisor) : OP_W'(divisor);
      rem  <= '0;
    end else if (busy) begin
      rem  <= take ? OP_W'(trial - {1'b0, den}) : trial[OP_W-1:0];
      work <= {work[PROD_W-2:0], take};
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Floor rounding: a negative quotient with a remainder steps one further down
  always_comb begin
    if (!neg) begin
      quotient = $signed(work);
    end else if (rem != '0) begin
      quotient = $signed(~work);
    end else begin
      quotient = $signed(-work);
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy == (cnt != '0))
    else $error("divider busy flag and step count disagree");

endmodule

// ===== design/spc_sequencer.sv =====
module spc_sequencer import spc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] command,
  input  stat_t            stat,
  output logic             in_ready,
  output ctl_t             ctl
);

  logic [ADDR_W-1:0] pc;
  logic [ADDR_W-1:0] pc_next;
  uword_t            word;

  assign word     = ucode_rom(pc);
  assign in_ready = (pc == A_IDLE);

  always_comb begin
    pc_next  = pc;
    ctl.uop  = word.uop;
    ctl.en   = 1'b1;
    ctl.load = 1'b0;
    unique case (word.cond)
      C_DISPATCH: begin
        if (in_valid) begin
          pc_next  = entry_of(command);
          ctl.load = 1'b1;
        end
      end
      C_NEXT: pc_next = pc + 1'b1;
      C_JUMP: pc_next = word.target;
      C_WAIT_DIV: begin
        if (stat.div_busy) begin
          ctl.en = 1'b0;
        end else begin
          pc_next = pc + 1'b1;
        end
      end
      C_SPAN0: pc_next = stat.span_zero ? word.target : pc + 1'b1;
      C_AWAKE: pc_next = stat.asleep ? pc + 1'b1 : word.target;
      C_EMIT: begin
        if (stat.out_full) begin
          ctl.en = 1'b0;
        end else begin
          pc_next = word.target;
        end
      end
      default: pc_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= A_LAST)
    else $error("step counter left the program");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (pc == A_EMIT && stat.out_full) |=> pc == A_EMIT)
    else $error("sequencer passed the emit step while the result register was full");

endmodule

// ===== design/spc_datapath.sv =====
module spc_datapath import spc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_t                    ctl,
  input  logic signed [AMT_W-1:0] amount,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    out_ready,
  output stat_t                   stat,
  output logic                    out_valid,
  output logic                    out_write_strobe,
  output logic [PUL_W-1:0]        out_pin_value,
  output logic signed [ANG_W-1:0] out_angle_now,
  output logic                    out_asleep
);

  logic signed [ANG_W-1:0] min_angle;
  logic signed [ANG_W-1:0] max_angle;
  logic [PUL_W-1:0]        min_pulse;
  logic [PUL_W-1:0]        max_pulse;

  logic signed [ANG_W-1:0] angle_reg;
  logic                    sleep_flag;
  logic [PUL_W-1:0]        last_pulse;

  logic signed [AMT_W-1:0] amt;
  logic signed [TGT_W-1:0] tgt;
  logic [PROD_W-1:0]       prod;
  logic                    strobe;
  logic [PUL_W-1:0]        pin;

  logic signed [OP_W-1:0]   span;
  logic signed [OP_W-1:0]   ang_diff;
  logic signed [OP_W-1:0]   pulse_diff;
  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic [PROD_W-1:0]        mul_prod;
  logic signed [OP_W-1:0]   div_divisor;
  logic                     div_start;
  logic                     div_busy;
  logic signed [PROD_W-1:0] q;
  logic signed [OP_W-1:0]   bound_sum;
  logic signed [TGT_W-1:0]  min_t;
  logic signed [TGT_W-1:0]  max_t;
  logic signed [ANG_W-1:0]  clamped;
  logic signed [SUM_W-1:0]  psum;
  logic [PUL_W-1:0]         psat;

  logic [PROD_W-1:0]        prod_neg;
  logic [PCT_MAG_W-1:0]     pct_mag;
  logic [2*PCT_MAG_W-1:0]   recip_prod;
  logic [PCT_Q_W-1:0]       pct_q;
  logic signed [TGT_W-1:0]  pct_delta;

  assign span       = {max_angle[ANG_W-1], max_angle} - {min_angle[ANG_W-1], min_angle};
  assign ang_diff   = {angle_reg[ANG_W-1], angle_reg} - {min_angle[ANG_W-1], min_angle};
  assign pulse_diff = {2'b00, max_pulse} - {2'b00, min_pulse};
  assign bound_sum  = {max_angle[ANG_W-1], max_angle} + {min_angle[ANG_W-1], min_angle};

  assign mul_a    = (ctl.uop == U_MUL_PCT) ? span : ang_diff;
  assign mul_b    = (ctl.uop == U_MUL_PCT) ? amt  : pulse_diff;
  // Low bits of a product of sign-extended operands carry the signed result
  assign mul_prod = {{OP_W{mul_a[OP_W-1]}}, mul_a} * {{OP_W{mul_b[OP_W-1]}}, mul_b};

  // Percent scaling: floor of a negative product is minus the rounded-up magnitude quotient
  assign prod_neg   = -prod;
  assign recip_prod = {{PCT_MAG_W{1'b0}}, pct_mag} * {{PCT_MAG_W{1'b0}}, RECIP_10K};
  assign pct_delta  = prod[PROD_W-1] ? -$signed(TGT_W'(pct_q)) : $signed(TGT_W'(pct_q));

  assign div_start   = ctl.en && (ctl.uop == U_DIV_SPAN);
  assign div_divisor = span;

  spc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ($signed(prod)),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (q)
  );

  // Clamp: lower bound is tested first
  assign min_t = TGT_W'(min_angle);
  assign max_t = TGT_W'(max_angle);
  always_comb begin
    if (tgt < min_t) begin
      clamped = min_angle;
    end else if (tgt > max_t) begin
      clamped = max_angle;
    end else begin
      clamped = tgt[ANG_W-1:0];
    end
  end

  // Pulse offset plus base, saturated to the pin code range
  assign psum = $signed({{(SUM_W-PUL_W){1'b0}}, min_pulse}) + $signed({q[PROD_W-1], q});
  always_comb begin
    if (psum[SUM_W-1]) begin
      psat = '0;
    end else if (psum[SUM_W-2:PUL_W] != '0) begin
      psat = PULSE_MAX_CODE;
    end else begin
      psat = psum[PUL_W-1:0];
    end
  end

  assign stat.div_busy  = div_busy;
  assign stat.span_zero = (max_angle == min_angle);
  assign stat.asleep    = sleep_flag;
  assign stat.out_full  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle  <= MIN_ANGLE_RST;
      max_angle  <= MAX_ANGLE_RST;
      min_pulse  <= MIN_PULSE_RST;
      max_pulse  <= MAX_PULSE_RST;
      angle_reg  <= '0;
      sleep_flag <= 1'b0;
      last_pulse <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_ANGLE: min_angle <= $signed(cfg_data);
          REG_MAX_ANGLE: max_angle <= $signed(cfg_data);
          REG_MIN_PULSE: min_pulse <= cfg_data[PUL_W-1:0];
          REG_MAX_PULSE: max_pulse <= cfg_data[PUL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && !(ctl.en && ctl.uop == U_EMIT)) begin
        out_valid <= 1'b0;
      end
      if (ctl.load) begin
        amt <= amount;
      end
      if (ctl.en) begin
        unique case (ctl.uop)
          U_TGT_AMT:   tgt <= TGT_W'(amt);
          U_TGT_REL:   tgt <= TGT_W'(angle_reg) + TGT_W'(amt);
          U_TGT_CTR:   tgt <= TGT_W'($signed(bound_sum[OP_W-1:1]));
          U_MUL_PCT:   prod <= mul_prod;
          U_MUL_PULSE: prod <= mul_prod;
          U_PCT_MAG: begin
            if (prod[PROD_W-1]) begin
              pct_mag <= prod_neg[PCT_MAG_W-1:0] + PCT_ROUND;
            end else begin
              pct_mag <= prod[PCT_MAG_W-1:0];
            end
          end
          U_PCT_RECIP: pct_q <= recip_prod[2*PCT_MAG_W-1:RECIP_SHIFT];
          U_TGT_Q:     tgt <= TGT_W'(angle_reg) + pct_delta;
          U_CLAMP:     angle_reg <= clamped;
          U_PULSE_Q:   last_pulse <= psat;
          U_PULSE_MIN: last_pulse <= min_pulse;
          U_DRIVE: begin
            strobe <= 1'b1;
            pin    <= last_pulse;
          end
          U_WAKE:      sleep_flag <= 1'b0;
          U_SLEEP: begin
            sleep_flag <= 1'b1;
            strobe     <= 1'b1;
            pin        <= '0;
          end
          U_NODRIVE: begin
            strobe <= 1'b0;
            pin    <= '0;
          end
          U_EMIT: begin
            out_valid        <= 1'b1;
            out_write_strobe <= strobe;
            out_pin_value    <= pin;
            out_angle_now    <= angle_reg;
            out_asleep       <= sleep_flag;
          end
          default: ;
        endcase
      end
    end
  end

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.en && ctl.uop == U_EMIT))
    else $error("result appeared without an emit step");
  a_quiet_pin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_write_strobe) |-> out_pin_value == '0)
    else $error("pin value nonzero on a result that drives nothing");

endmodule

// ===== design/servo_angle_pulse_controller_top.sv =====
// Servo angle to pulse width controller.
// cmd carries one command transaction (command, amount); res returns exactly one
// result transaction per command (write_strobe, pin_value, angle_now, asleep).
// The cfg_we/cfg_index/cfg_data port writes min_angle, max_angle, min_pulse and
// max_pulse; write only while no command is in flight.
// A microcoded sequencer steps a small program per command. move_to,
// move_by_degrees, center, move_by_percent and wake-from-sleep run the signed
// span divide; sleep, unknown codes and wake while awake skip it. With equal
// angle bounds the divide is skipped. The divider for the angle span retires
// one quotient bit per cycle over 34 steps, plus one step to hand over.
// Percent moves scale by 10000 through a reciprocal multiply in three steps.
// One command is in work at a time: cmd.ready is high only in the idle step,
// which follows the emit step, so a command is taken only once the previous
// one has passed its emit step. The result sits in an output register, so the
// next command is taken while it waits. If res is stalled and a second result
// is finished, the sequencer holds in its emit step until the register frees.
// Reset (rst, synchronous) restores the configuration defaults, zeroes the angle,
// sleep flag and last pulse, empties the result register and idles the sequencer.
module servo_angle_pulse_controller_top import spc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  spc_cmd_if.sink              cmd,
  spc_res_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctl_t  ctl;
  stat_t stat;

  // Step counter, control store and jump logic
  spc_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .command  (cmd.command),
    .stat     (stat),
    .in_ready (cmd.ready),
    .ctl      (ctl)
  );

  // Configuration, servo state, multiplier, divider and result register
  spc_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .amount           (cmd.amount),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ready        (res.ready),
    .stat             (stat),
    .out_valid        (res.valid),
    .out_write_strobe (res.write_strobe),
    .out_pin_value    (res.pin_value),
    .out_angle_now    (res.angle_now),
    .out_asleep       (res.asleep)
  );

endmodule

// ===== tb/tb_servo_angle_pulse_controller_top.sv =====
module tb_servo_angle_pulse_controller_top;
  import spc_pkg::*;

  // Command codes the block must ignore (no state change, pin not driven)
  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

  // Run pacing
  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 8;     // quiet gap before touching the registers
  localparam int TAIL_CYCLES     = 100;   // extra cycles after the last result
  localparam int RES_HOLD_CYCLES = 400;   // long result back-pressure stretch
  localparam int STALL_LIMIT     = 5000;  // cycles with no transaction before giving up
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic                    strobe;
    logic [PUL_W-1:0]        pin;
    logic signed [ANG_W-1:0] angle;
    logic                    asleep;
  } servo_state_t;

  // Tracks the servo the way the block should, queues the state each command
  // must report, and compares what comes back.
  class servo_pulse_scoreboard;
    logic signed [ANG_W-1:0] lo_angle;
    logic signed [ANG_W-1:0] hi_angle;
    logic [PUL_W-1:0]        lo_pulse;
    logic [PUL_W-1:0]        hi_pulse;
    logic signed [ANG_W-1:0] angle;
    logic                    sleeping;
    logic [PUL_W-1:0]        last_pulse;
    servo_state_t            awaited_states[$];
    int                      errors;

    function new();
      lo_angle   = MIN_ANGLE_RST;
      hi_angle   = MAX_ANGLE_RST;
      lo_pulse   = MIN_PULSE_RST;
      hi_pulse   = MAX_PULSE_RST;
      angle      = '0;
      sleeping   = 1'b0;
      last_pulse = '0;
      errors     = 0;
    endfunction

    function int pending();
      return awaited_states.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_MIN_ANGLE: lo_angle = data;
        REG_MAX_ANGLE: hi_angle = data;
        REG_MIN_PULSE: lo_pulse = data[PUL_W-1:0];
        REG_MAX_PULSE: hi_pulse = data[PUL_W-1:0];
        default: ;
      endcase
    endfunction

    // Division rounded toward minus infinity
    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0)))
        q = q - 1;
      return q;
    endfunction

    // Lower bound wins, so reversed bounds always land on one of the two
    function logic signed [ANG_W-1:0] clamp_angle(longint t);
      if (t < longint'(lo_angle))
        return lo_angle;
      if (t > longint'(hi_angle))
        return hi_angle;
      return t[ANG_W-1:0];
    endfunction

    function logic [PUL_W-1:0] pulse_at(longint ang);
      longint span;
      longint p;
      span = longint'(hi_angle) - longint'(lo_angle);
      if (span == 0)
        p = longint'(lo_pulse);
      else
        p = longint'(lo_pulse) + floor_div((ang - longint'(lo_angle)) *
            (longint'(hi_pulse) - longint'(lo_pulse)), span);
      if (p < 0)
        p = 0;
      if (p > longint'(PULSE_MAX_CODE))
        p = longint'(PULSE_MAX_CODE);
      return p[PUL_W-1:0];
    endfunction

    function void note_command(logic [CMD_W-1:0] op, logic signed [AMT_W-1:0] amt);
      servo_state_t r;
      logic         move;
      longint       target;
      r.strobe = 1'b0;
      r.pin    = '0;
      move     = 1'b0;
      target   = 0;
      case (op)
        CMD_MOVE_TO: begin
          target = longint'(amt);
          move   = 1'b1;
        end
        CMD_MOVE_BY_DEG: begin
          target = longint'(angle) + longint'(amt);
          move   = 1'b1;
        end
        CMD_MOVE_BY_PCT: begin
          target = longint'(angle) + floor_div((longint'(hi_angle) - longint'(lo_angle)) *
                   longint'(amt), longint'(PCT_SCALE));
          move   = 1'b1;
        end
        CMD_CENTER: begin
          target = floor_div(longint'(lo_angle) + longint'(hi_angle), 2);
          move   = 1'b1;
        end
        CMD_SLEEP: begin
          r.strobe = 1'b1;
          sleeping = 1'b1;
        end
        CMD_WAKE: begin
          if (sleeping) begin
            last_pulse = pulse_at(longint'(angle));
            r.strobe   = 1'b1;
            r.pin      = last_pulse;
            sleeping   = 1'b0;
          end
        end
        default: ;
      endcase
      if (move) begin
        angle      = clamp_angle(target);
        last_pulse = pulse_at(longint'(angle));
        r.strobe   = 1'b1;
        r.pin      = last_pulse;
      end
      r.angle  = angle;
      r.asleep = sleeping;
      awaited_states.push_back(r);
    endfunction

    function void check_result(logic strobe, logic [PUL_W-1:0] pin,
                               logic signed [ANG_W-1:0] ang, logic slp);
      servo_state_t want;
      if (awaited_states.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: strobe=%0b pin=%0d angle=%0d asleep=%0b",
                   strobe, pin, ang, slp);
      end else begin
        want = awaited_states.pop_front();
        if (want.strobe !== strobe || want.pin !== pin ||
            want.angle !== ang || want.asleep !== slp) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: expected strobe=%0b pin=%0d angle=%0d asleep=%0b, %s",
                     want.strobe, want.pin, want.angle, want.asleep,
                     $sformatf("got strobe=%0b pin=%0d angle=%0d asleep=%0b",
                               strobe, pin, ang, slp));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  spc_cmd_if cmd_bus ();
  spc_res_if res_bus ();

  servo_pulse_scoreboard pulse_sb;

  // Idle rates in percent per cycle; the main sequence switches them per regime
  int send_idle_pct = 10;
  int recv_idle_pct = 82;
  // Raised by the main sequence to ask the result side for a long hold-off
  bit hold_results  = 1'b0;
  int quiet_cycles  = 0;

  servo_angle_pulse_controller_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_bus),
    .res       (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: take a result whenever ready meets valid; ready idles at random,
  // and on request holds low for a long stretch so the block backs up into
  // its command input.
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        res_bus.ready <= 1'b0;
        repeat (RES_HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every result transaction against the oldest awaited state
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready)
      pulse_sb.check_result(res_bus.write_strobe, res_bus.pin_value,
                            res_bus.angle_now, res_bus.asleep);
  end

  // Watchdog: give up once nothing has moved on either channel for too long
  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_servo_angle_pulse_controller_top: errors");
      $finish;
    end
  end

  // Offer one command transaction, idling first at the sender's rate, and hold
  // it until accepted. Valid stays high on return; the caller drops it when no
  // further command follows.
  task automatic offer(logic [CMD_W-1:0] op, int amt);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.command <= op;
    cmd_bus.amount  <= AMT_W'(amt);
    do @(posedge clk); while (!cmd_bus.ready);
    pulse_sb.note_command(op, AMT_W'(amt));
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    pulse_sb.set_register(idx, CFG_W'(val));
  endtask

  // Reprogram all four registers once the block has gone quiet
  task automatic load_settings(int lo_a, int hi_a, int lo_p, int hi_p);
    while (pulse_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(REG_MIN_ANGLE, lo_a);
    write_register(REG_MAX_ANGLE, hi_a);
    write_register(REG_MIN_PULSE, lo_p);
    write_register(REG_MAX_PULSE, hi_p);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random commands under the current settings. Open with sleep then wake so the
  // wake pulse is computed for an angle left over from the previous settings.
  task automatic random_burst(int count, bit squeeze);
    int               n;
    int               r;
    int               s;
    int               amt;
    logic [CMD_W-1:0] op;
    offer(CMD_SLEEP, 0);
    offer(CMD_WAKE, 0);
    if (squeeze)
      hold_results = 1'b1;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 22)      op = CMD_MOVE_TO;
      else if (r < 42) op = CMD_MOVE_BY_DEG;
      else if (r < 62) op = CMD_MOVE_BY_PCT;
      else if (r < 70) op = CMD_CENTER;
      else if (r < 80) op = CMD_SLEEP;
      else if (r < 92) op = CMD_WAKE;
      else             op = r[0] ? CMD_RSVD_A : CMD_RSVD_B;
      s = $urandom_range(99);
      if (s < 55)
        amt = int'($urandom_range(72000)) - 36000;
      else if (s < 75)
        amt = int'($urandom_range(2000)) - 1000;
      else if (s < 90)
        amt = int'($urandom_range(20000)) - 10000;
      else begin
        case ($urandom_range(4))
          0:       amt = -36000;
          1:       amt = 36000;
          2:       amt = -1;
          3:       amt = 1;
          default: amt = 0;
        endcase
      end
      offer(op, amt);
    end
    cmd_bus.valid <= 1'b0;
  endtask

  initial begin
    pulse_sb        = new();
    cmd_bus.valid   = 1'b0;
    cmd_bus.command = '0;
    cmd_bus.amount  = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed pass under the reset settings (0..180 deg, 500..2500 us)
    offer(CMD_WAKE, 0);               // awake already: pin not driven
    offer(CMD_MOVE_TO, 36000);        // clamp at the top
    offer(CMD_MOVE_TO, -36000);       // clamp at the bottom
    offer(CMD_MOVE_TO, 9001);
    offer(CMD_MOVE_BY_DEG, 0);
    offer(CMD_MOVE_BY_DEG, 36000);
    offer(CMD_MOVE_BY_DEG, -36000);
    offer(CMD_MOVE_BY_PCT, 10000);    // full span up
    offer(CMD_MOVE_BY_PCT, -36000);
    offer(CMD_MOVE_BY_PCT, 3333);
    offer(CMD_MOVE_BY_PCT, -1);       // negative delta rounds down
    offer(CMD_CENTER, -1);
    offer(CMD_SLEEP, 36000);
    offer(CMD_SLEEP, 0);              // sleep twice
    offer(CMD_MOVE_TO, 12345);        // move while asleep keeps the flag
    offer(CMD_WAKE, 0);               // asleep: re-drive the pulse
    offer(CMD_RSVD_A, -1);            // ignored codes
    offer(CMD_RSVD_B, 36000);
    offer(CMD_MOVE_BY_DEG, -1);
    cmd_bus.valid <= 1'b0;

    // Regime 1: sender mostly busy, receiver mostly stalled
    send_idle_pct = 10;
    recv_idle_pct = 82;
    load_settings(-18000, 18000, 0, 20000);         // widest ranges
    random_burst(300, 1'b0);
    load_settings(18000, -18000, 20000, 0);         // reversed bounds
    random_burst(150, 1'b1);

    // Regime 2: sender mostly idle, receiver mostly ready
    send_idle_pct = 82;
    recv_idle_pct = 10;
    s_equal: begin
      int a;
      a = int'($urandom_range(36000)) - 18000;
      load_settings(a, a, int'($urandom_range(20000)), int'($urandom_range(20000)));
    end
    random_burst(150, 1'b0);
    load_settings(-100, -99, 0, 20000);             // one-step span, pulse saturates
    random_burst(150, 1'b0);
    load_settings(int'($urandom_range(36000)) - 18000, int'($urandom_range(36000)) - 18000,
                  int'($urandom_range(20000)), int'($urandom_range(20000)));
    random_burst(300, 1'b0);

    // Regime 3: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings(int'($urandom_range(36000)) - 18000, int'($urandom_range(36000)) - 18000,
                  int'($urandom_range(20000)), int'($urandom_range(20000)));
    random_burst(300, 1'b1);
    load_settings(int'($urandom_range(36000)) - 18000, int'($urandom_range(36000)) - 18000,
                  int'($urandom_range(20000)), int'($urandom_range(20000)));
    random_burst(300, 1'b0);
    load_settings(MIN_ANGLE_RST, MAX_ANGLE_RST, MIN_PULSE_RST, MAX_PULSE_RST);
    random_burst(150, 1'b0);

    // Drain, let the block settle, then report
    while (pulse_sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pulse_sb.errors == 0 && pulse_sb.pending() == 0)
      $display("tb_servo_angle_pulse_controller_top: clean");
    else
      $display("tb_servo_angle_pulse_controller_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
design/spc_pkg.sv
design/spc_if.sv
design/spc_divider.sv
design/spc_sequencer.sv
design/spc_datapath.sv
design/servo_angle_pulse_controller_top.sv
tb/tb_servo_angle_pulse_controller_top.sv
